/* rtl/srr_pkg.sv */
// Package for the sensor parameter read requester.
// Holds the item structs, the phase enum and the frame and code constants.
// No dependencies.
package srr_pkg;

	// Command codes of an input item
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_RX    = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Result kinds
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Completion status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TIMEOUT  = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;
	localparam logic [1:0] ST_DEVFAIL  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_PRE_SEND_WAIT    = 3'd0;
	localparam logic [2:0] CFG_IDLE_BEFORE_SEND = 3'd1;
	localparam logic [2:0] CFG_REPLY_TIMEOUT    = 3'd2;
	localparam logic [2:0] CFG_MISMATCH_WAIT    = 3'd3;
	localparam logic [2:0] CFG_ATTEMPT_LIMIT    = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Frame constants
	localparam logic [7:0] FUNC_READ  = 8'h52;
	localparam logic [7:0] REPLY_FLAG = 8'h80;
	localparam logic [7:0] FAIL_CODE  = 8'hFF;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [15:0] WAIT_MAX  = 16'hFFFF;

	localparam int FRAME_LEN = 8;
	localparam int BEAT_W    = $clog2(FRAME_LEN);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_DRAIN,
		PH_COLLECT,
		PH_MISWAIT
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] dev_addr;
		logic [7:0] param_code;
		logic [7:0] rx_byte;
	} srr_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic [1:0]  status;
		logic [31:0] read_value;
		logic        last;
	} srr_out_t;

endpackage

/* rtl/sensor_param_read_requester_core.sv */
// Sensor parameter read requester, top level.
// Sequences attempts, emits request frames and checks replies.
// Depends on srr_pkg.
//
// Output: an accepted item's first result is registered and shows on the output in the cycle after.
// Throughput: one item per cycle while the output accepts; an item that sends a request
// frame holds the input until the last of the eight frame bytes leaves, set by the single
// output job register that plays the frame out one byte a cycle while out_ready is high.
// Reset: arst_n clears phase, counters, request registers, configuration (to its
// reset values) and the output job; the reply byte store is not cleared.
module sensor_param_read_requester_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  srr_pkg::srr_in_t                  in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output srr_pkg::srr_out_t                 out_item,
	input  logic                              cfg_we,
	input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import srr_pkg::*;

	// Configuration registers
	logic [15:0] cfg_pre_q;
	logic [7:0]  cfg_idle_q;
	logic [15:0] cfg_timeout_q;
	logic [15:0] cfg_mis_q;
	logic [3:0]  cfg_limit_q;

	// Sequencer state
	phase_t      phase_q, phase_n;
	logic [15:0] wait_q, wait_n;
	logic [3:0]  attempt_q, attempt_n;
	logic [3:0]  byte_q, byte_n;
	logic [7:0]  req_addr_q, req_addr_n;
	logic [7:0]  req_param_q, req_param_n;
	logic [1:0]  err_q, err_n;

	// Reply byte store: each entry written before it is read within an attempt
	logic [7:0]  reply_q [FRAME_LEN];
	logic        reply_we;

	// Output job: either a request frame played out by beat, or one completion
	logic              job_v_q;
	logic              job_frame_q;
	logic [BEAT_W-1:0] beat_q;
	logic [7:0]        job_addr_q;
	logic [7:0]        job_param_q;
	logic [7:0]        job_sum_q;
	logic [1:0]        job_status_q;
	logic [31:0]       job_value_q;

	// Job request from the sequencer
	logic        new_frame;
	logic        new_done;
	logic [1:0]  done_status;
	logic [31:0] done_value;

	logic        fire;
	logic        out_fire;

	// Scratch for the next-state block
	logic [15:0] w_dec, w_inc;
	logic        end_attempt;
	logic [3:0]  att_inc;
	logic [7:0]  sum7;

	assign fire     = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Hold the input whenever a job is waiting, unless its final beat leaves now
	assign in_ready  = !job_v_q || (out_ready && out_item.last);
	assign out_valid = job_v_q;

	//--------------------------------------------------------------------------
	// Configuration port
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pre_q     <= 16'd10;
			cfg_idle_q    <= 8'd5;
			cfg_timeout_q <= 16'd100;
			cfg_mis_q     <= 16'd10;
			cfg_limit_q   <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRE_SEND_WAIT:    cfg_pre_q     <= cfg_data;
				CFG_IDLE_BEFORE_SEND: cfg_idle_q    <= cfg_data[7:0];
				CFG_REPLY_TIMEOUT:    cfg_timeout_q <= cfg_data;
				CFG_MISMATCH_WAIT:    cfg_mis_q     <= cfg_data;
				CFG_ATTEMPT_LIMIT:    cfg_limit_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Next state: the whole effect of one item, in a single pass
	//--------------------------------------------------------------------------
	always_comb begin
		phase_n     = phase_q;
		wait_n      = wait_q;
		attempt_n   = attempt_q;
		byte_n      = byte_q;
		req_addr_n  = req_addr_q;
		req_param_n = req_param_q;
		err_n       = err_q;
		reply_we    = 1'b0;
		new_frame   = 1'b0;
		new_done    = 1'b0;
		done_status = ST_OK;
		done_value  = 32'd0;
		end_attempt = 1'b0;

		w_dec   = (wait_q != 16'd0) ? wait_q - 16'd1 : wait_q;
		w_inc   = (wait_q != WAIT_MAX) ? wait_q + 16'd1 : wait_q;
		att_inc = attempt_q + 4'd1;

		// Checksum over the seven stored reply bytes
		sum7 = 8'd0;
		for (int i = 0; i < FRAME_LEN - 1; i++) begin
			sum7 = sum7 + reply_q[i];
		end

		case (in_item.command)
			CMD_START: begin
				req_addr_n  = in_item.dev_addr;
				req_param_n = in_item.param_code;
				attempt_n   = 4'd0;
				byte_n      = 4'd0;
				err_n       = ST_DEVFAIL;
				if (cfg_limit_q == 4'd0) begin
					phase_n     = PH_IDLE;
					new_done    = 1'b1;
					done_status = ST_DEVFAIL;
				end else if (cfg_pre_q == 16'd0) begin
					phase_n = PH_DRAIN;
					wait_n  = 16'd0;
				end else begin
					phase_n = PH_PRE;
					wait_n  = cfg_pre_q;
				end
			end
			CMD_RX: begin
				if (phase_q == PH_DRAIN) begin
					// A byte on the line restarts the silence count
					wait_n = 16'd0;
				end else if (phase_q == PH_COLLECT) begin
					reply_we = 1'b1;
					byte_n   = byte_q + 4'd1;
					if (byte_n >= 4'(FRAME_LEN)) begin
						// Eighth byte: the incoming byte is the checksum
						if (sum7 != in_item.rx_byte) begin
							err_n       = ST_CHECKSUM;
							end_attempt = 1'b1;
						end else begin
							if (reply_q[0] != req_addr_q ||
							    reply_q[1] != (FUNC_READ | REPLY_FLAG)) begin
								err_n = ST_TIMEOUT;
							end else if (reply_q[6] == FAIL_CODE ||
							             reply_q[6] != req_param_q) begin
								err_n = ST_DEVFAIL;
							end
							if (err_n == ST_TIMEOUT || err_n == ST_DEVFAIL) begin
								if (reply_q[0] == req_addr_q &&
								    reply_q[1] == (FUNC_READ | REPLY_FLAG) &&
								    reply_q[6] != FAIL_CODE &&
								    reply_q[6] == req_param_q) begin
									// Good reply while a stale error code is held
									phase_n     = PH_IDLE;
									new_done    = 1'b1;
									done_status = ST_OK;
									done_value  = {reply_q[5], reply_q[4],
									               reply_q[3], reply_q[2]};
									err_n       = err_q;
								end else if (cfg_mis_q == 16'd0) begin
									end_attempt = 1'b1;
								end else begin
									phase_n = PH_MISWAIT;
									wait_n  = cfg_mis_q;
								end
							end else begin
								phase_n     = PH_IDLE;
								new_done    = 1'b1;
								done_status = ST_OK;
								done_value  = {reply_q[5], reply_q[4],
								               reply_q[3], reply_q[2]};
							end
						end
					end
				end
			end
			CMD_TICK: begin
				case (phase_q)
					PH_PRE: begin
						if (w_dec == 16'd0) begin
							phase_n = PH_DRAIN;
							wait_n  = 16'd0;
						end else begin
							wait_n = w_dec;
						end
					end
					PH_DRAIN: begin
						if (w_inc >= {8'd0, cfg_idle_q}) begin
							// Line quiet long enough: send the request
							phase_n   = PH_COLLECT;
							byte_n    = 4'd0;
							wait_n    = 16'd0;
							new_frame = 1'b1;
						end else begin
							wait_n = w_inc;
						end
					end
					PH_COLLECT: begin
						wait_n = w_inc;
						if (w_inc >= cfg_timeout_q) begin
							err_n       = ST_TIMEOUT;
							end_attempt = 1'b1;
						end
					end
					PH_MISWAIT: begin
						wait_n = w_dec;
						if (w_dec == 16'd0) begin
							end_attempt = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// Attempt over: retry or report the error just recorded
		if (end_attempt) begin
			attempt_n = att_inc;
			if (att_inc >= cfg_limit_q) begin
				phase_n     = PH_IDLE;
				new_done    = 1'b1;
				done_status = err_n;
			end else if (cfg_pre_q == 16'd0) begin
				phase_n = PH_DRAIN;
				wait_n  = 16'd0;
			end else begin
				phase_n = PH_PRE;
				wait_n  = cfg_pre_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			wait_q      <= 16'd0;
			attempt_q   <= 4'd0;
			byte_q      <= 4'd0;
			req_addr_q  <= 8'd0;
			req_param_q <= 8'd0;
			err_q       <= ST_DEVFAIL;
		end else if (fire) begin
			phase_q     <= phase_n;
			wait_q      <= wait_n;
			attempt_q   <= attempt_n;
			byte_q      <= byte_n;
			req_addr_q  <= req_addr_n;
			req_param_q <= req_param_n;
			err_q       <= err_n;
		end
	end

	// Reply store, written by collected bytes
	always_ff @(posedge clk) begin
		if (fire && reply_we) begin
			reply_q[byte_q[BEAT_W-1:0]] <= in_item.rx_byte;
		end
	end

	//--------------------------------------------------------------------------
	// Output job register
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q     <= 1'b0;
			job_frame_q <= 1'b0;
			beat_q      <= '0;
		end else if (fire && (new_frame || new_done)) begin
			job_v_q     <= 1'b1;
			job_frame_q <= new_frame;
			beat_q      <= '0;
		end else if (out_fire) begin
			if (out_item.last) begin
				job_v_q <= 1'b0;
			end else begin
				beat_q <= beat_q + BEAT_W'(1);
			end
		end
	end

	// Job payload, loaded with the job
	always_ff @(posedge clk) begin
		if (fire && (new_frame || new_done)) begin
			job_addr_q   <= req_addr_q;
			job_param_q  <= req_param_q;
			job_sum_q    <= req_addr_q + FUNC_READ + req_param_q;
			job_status_q <= done_status;
			job_value_q  <= done_value;
		end
	end

	//--------------------------------------------------------------------------
	// Outputs: pick the frame byte for this beat, or present the completion
	//--------------------------------------------------------------------------
	always_comb begin
		out_item = '0;
		if (job_frame_q) begin
			out_item.kind = KIND_TX;
			out_item.last = (beat_q == BEAT_W'(FRAME_LEN - 1));
			case (beat_q)
				3'd0:    out_item.tx_byte = job_addr_q;
				3'd1:    out_item.tx_byte = FUNC_READ;
				3'd6:    out_item.tx_byte = job_param_q;
				3'd7:    out_item.tx_byte = job_sum_q;
				default: out_item.tx_byte = ZERO_BYTE;
			endcase
		end else begin
			out_item.kind       = KIND_DONE;
			out_item.status     = job_status_q;
			out_item.read_value = job_value_q;
			out_item.last       = 1'b1;
		end
	end

	//--------------------------------------------------------------------------
	// Assertions
	//--------------------------------------------------------------------------
	// Never take an item while a job stays behind on the output
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(job_v_q && !(out_ready && out_item.last)) |-> !in_ready)
		else $error("input accepted while an output job is still pending");

	// A request frame, once begun, keeps going until its final byte
	a_frame_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && job_frame_q && !out_item.last) |=> (out_valid && job_frame_q))
		else $error("request frame broken off before its last byte");

	// Collection never counts past a full reply
	a_byte_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLLECT) |-> (byte_q < 4'(FRAME_LEN)))
		else $error("reply byte count out of range");

	// A completion is always the final result of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !job_frame_q) |-> (out_item.kind == KIND_DONE && out_item.last))
		else $error("completion not marked as final");

endmodule

/* bench/sensor_param_read_requester_core_tb.sv */
// Testbench for sensor_param_read_requester_core: random reads, a directed table, then more random read sequences.
// An in-bench model of the requester predicts every transmit byte and completion.
// Depends on srr_pkg and the core RTL only.
`timescale 1ns / 100ps

module sensor_param_read_requester_core_tb;
	import srr_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 12;   // covers the output job playing out an eight-byte frame
	localparam int RX_HOLD       = 400;  // long receiver hold-off under pressure
	localparam int STALL_LIMIT   = 5000; // cycles with no handshake before giving up
	localparam int SHOW_MAX      = 100;  // mismatches printed before going quiet

	// Command code that the block ignores
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		bit         reg_row;
		logic [2:0] reg_idx;
		logic [15:0] reg_val;
		srr_in_t    item;
		bit         typed;
		srr_out_t   want;
	} step_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	srr_in_t  in_item;
	logic     out_valid;
	logic     out_ready;
	srr_out_t out_item;
	logic     cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Configuration copy, at reset values
	logic [15:0] cfg_pre   = 16'd10;
	logic [7:0]  cfg_idle  = 8'd5;
	logic [15:0] cfg_tmo   = 16'd100;
	logic [15:0] cfg_mis   = 16'd10;
	logic [3:0]  cfg_limit = 4'd3;

	// Requester state as the block should hold it
	phase_t      rq_phase = PH_IDLE;
	logic [15:0] rq_wait  = '0;
	logic [3:0]  rq_tries = '0;
	logic [3:0]  rq_beats = '0;
	logic [7:0]  rq_reply [8];
	logic [7:0]  rq_addr  = '0;
	logic [7:0]  rq_param = '0;
	logic [1:0]  rq_err   = ST_DEVFAIL;

	srr_out_t  owed_q [$];   // results the block still owes, oldest first
	bit        owe_muted;    // drop model results on rows with a typed expectation
	step_row_t script [$];

	// Random sequence shaping
	logic [7:0] reply_plan [8];
	int         drain_noise;
	bit         stall_reply;

	bit no_gaps;
	bit hold_req;
	int errors;
	int stall_cycles;

	sensor_param_read_requester_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------- model

	function automatic void owe(logic kind, logic [7:0] tx, logic [1:0] st,
			logic [31:0] value, logic last);
		srr_out_t r;
		r.kind       = kind;
		r.tx_byte    = tx;
		r.status     = st;
		r.read_value = value;
		r.last       = last;
		if (!owe_muted)
			owed_q.push_back(r);
	endfunction

	function automatic void close_read(logic [1:0] st, logic [31:0] value);
		rq_phase = PH_IDLE;
		owe(KIND_DONE, ZERO_BYTE, st, value, 1'b1);
	endfunction

	// A zero pre-send wait skips straight to the silence count
	function automatic void open_attempt();
		if (cfg_pre == 16'd0) begin
			rq_phase = PH_DRAIN;
			rq_wait  = '0;
		end else begin
			rq_phase = PH_PRE;
			rq_wait  = cfg_pre;
		end
	endfunction

	function automatic void retry_or_report();
		rq_tries = rq_tries + 4'd1;
		if (rq_tries >= cfg_limit)
			close_read(rq_err, '0);
		else
			open_attempt();
	endfunction

	function automatic void run_requester(srr_in_t it);
		logic [7:0] frame [8];
		logic [7:0] sum;
		case (it.command)
			CMD_START: begin
				rq_addr  = it.dev_addr;
				rq_param = it.param_code;
				rq_tries = '0;
				rq_beats = '0;
				rq_err   = ST_DEVFAIL;
				if (cfg_limit == 4'd0)
					close_read(rq_err, '0);
				else
					open_attempt();
			end
			CMD_RX: begin
				if (rq_phase == PH_DRAIN) begin
					rq_wait = '0;
				end else if (rq_phase == PH_COLLECT) begin
					rq_reply[rq_beats[2:0]] = it.rx_byte;
					rq_beats = rq_beats + 4'd1;
					if (rq_beats >= 4'd8) begin
						sum = '0;
						for (int k = 0; k < 7; k++)
							sum = sum + rq_reply[k];
						if (sum != rq_reply[7]) begin
							rq_err = ST_CHECKSUM;
							retry_or_report();
						end else if (rq_reply[0] == rq_addr
								&& rq_reply[1] == (FUNC_READ | REPLY_FLAG)
								&& rq_reply[6] != FAIL_CODE && rq_reply[6] == rq_param) begin
							close_read(ST_OK, {rq_reply[5], rq_reply[4], rq_reply[3],
								rq_reply[2]});
						end else begin
							// Header mismatch shares its code with a timeout
							if (rq_reply[0] != rq_addr || rq_reply[1] != (FUNC_READ | REPLY_FLAG))
								rq_err = ST_TIMEOUT;
							else
								rq_err = ST_DEVFAIL;
							if (cfg_mis == 16'd0) begin
								retry_or_report();
							end else begin
								rq_phase = PH_MISWAIT;
								rq_wait  = cfg_mis;
							end
						end
					end
				end
			end
			CMD_TICK: begin
				case (rq_phase)
					PH_PRE: begin
						if (rq_wait != 16'd0)
							rq_wait = rq_wait - 16'd1;
						if (rq_wait == 16'd0)
							rq_phase = PH_DRAIN;
					end
					PH_DRAIN: begin
						if (rq_wait != WAIT_MAX)
							rq_wait = rq_wait + 16'd1;
						if (rq_wait >= {8'd0, cfg_idle}) begin
							frame[0] = rq_addr;
							frame[1] = FUNC_READ;
							frame[2] = ZERO_BYTE;
							frame[3] = ZERO_BYTE;
							frame[4] = ZERO_BYTE;
							frame[5] = ZERO_BYTE;
							frame[6] = rq_param;
							sum = '0;
							for (int k = 0; k < 7; k++)
								sum = sum + frame[k];
							frame[7] = sum;
							for (int k = 0; k < 8; k++)
								owe(KIND_TX, frame[k], ST_OK, '0, k == 7);
							rq_phase = PH_COLLECT;
							rq_beats = '0;
							rq_wait  = '0;
						end
					end
					PH_COLLECT: begin
						if (rq_wait != WAIT_MAX)
							rq_wait = rq_wait + 16'd1;
						if (rq_wait >= cfg_tmo) begin
							rq_err = ST_TIMEOUT;
							retry_or_report();
						end
					end
					PH_MISWAIT: begin
						if (rq_wait != 16'd0)
							rq_wait = rq_wait - 16'd1;
						if (rq_wait == 16'd0)
							retry_or_report();
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic srr_in_t mk_item(logic [1:0] cmd, logic [7:0] addr,
			logic [7:0] param, logic [7:0] rx);
		srr_in_t it;
		it.command    = cmd;
		it.dev_addr   = addr;
		it.param_code = param;
		it.rx_byte    = rx;
		return it;
	endfunction

	// Unused fields carry noise so that the block must ignore them
	function automatic srr_in_t rand_item(logic [1:0] cmd);
		return mk_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	function automatic step_row_t row_reg(logic [2:0] idx, logic [15:0] value);
		step_row_t r;
		r = '{default: '0};
		r.reg_row = 1'b1;
		r.reg_idx = idx;
		r.reg_val = value;
		return r;
	endfunction

	function automatic step_row_t row_item(logic [1:0] cmd, logic [7:0] addr,
			logic [7:0] param, logic [7:0] rx);
		step_row_t r;
		r = '{default: '0};
		r.item = mk_item(cmd, addr, param, rx);
		return r;
	endfunction

	// Row whose single result is a completion typed in by hand
	function automatic step_row_t row_done(logic [1:0] cmd, logic [7:0] addr,
			logic [7:0] param, logic [7:0] rx, logic [1:0] st, logic [31:0] value);
		step_row_t r;
		r = row_item(cmd, addr, param, rx);
		r.typed           = 1'b1;
		r.want.kind       = KIND_DONE;
		r.want.tx_byte    = ZERO_BYTE;
		r.want.status     = st;
		r.want.read_value = value;
		r.want.last       = 1'b1;
		return r;
	endfunction

	// Choose the next item from where the requester stands: mostly well-formed reads,
	// with stray bytes, dropped replies, corrupt replies and abandoned starts mixed in.
	function automatic srr_in_t pick_item();
		srr_in_t    it;
		logic [7:0] sum;
		int         shape;
		it = rand_item(CMD_TICK);
		case (rq_phase)
			PH_IDLE: begin
				if ($urandom_range(9) == 0)
					it.command = 2'($urandom_range(1, 3));
				else
					it.command = CMD_START;
			end
			PH_COLLECT: begin
				if (rq_beats == 4'd0 && $urandom_range(9) == 0)
					stall_reply = 1'b1;
				if (!stall_reply && $urandom_range(15) != 0) begin
					if (rq_beats == 4'd0) begin
						shape = $urandom_range(11);
						reply_plan[0] = rq_addr;
						reply_plan[1] = FUNC_READ | REPLY_FLAG;
						for (int k = 2; k < 6; k++)
							reply_plan[k] = 8'($urandom);
						reply_plan[6] = rq_param;
						case (shape)
							0: reply_plan[0] ^= 8'($urandom_range(1, 255));
							1: reply_plan[1] ^= 8'($urandom_range(1, 255));
							2: reply_plan[6] = FAIL_CODE;
							3: reply_plan[6] ^= 8'($urandom_range(1, 255));
							default: ;
						endcase
						sum = '0;
						for (int k = 0; k < 7; k++)
							sum = sum + reply_plan[k];
						reply_plan[7] = sum;
						if (shape == 4)
							reply_plan[7] ^= 8'($urandom_range(1, 255));
						if (shape == 5)
							for (int k = 0; k < 8; k++)
								reply_plan[k] = 8'($urandom);
					end
					it.command = CMD_RX;
					it.rx_byte = reply_plan[rq_beats[2:0]];
				end
			end
			default: begin
				stall_reply = 1'b0;
				if ($urandom_range(63) == 0) begin
					it.command = CMD_START;
				end else if (rq_phase == PH_DRAIN) begin
					// Ration stray bytes so the silence count can still complete
					if (drain_noise > 0 && $urandom_range(3) == 0) begin
						it.command = CMD_RX;
						drain_noise--;
					end
				end else if ($urandom_range(31) == 0) begin
					it.command = CMD_RX;
				end
			end
		endcase
		if (it.command == CMD_START)
			drain_noise = $urandom_range(2);
		return it;
	endfunction

	// ---------------------------------------------------------------- driving

	// Offer one item, hold it until taken, then advance the model
	task automatic send_item(srr_in_t it, bit typed = 1'b0, srr_out_t want = '0);
		while (!no_gaps && $urandom_range(99) < 6) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		owe_muted = typed;
		run_requester(it);
		owe_muted = 1'b0;
		if (typed)
			owed_q.push_back(want);
	endtask

	// Drop valid and wait until every owed result has come, plus the tail latency
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PRE_SEND_WAIT:    cfg_pre   = value;
			CFG_IDLE_BEFORE_SEND: cfg_idle  = value[7:0];
			CFG_REPLY_TIMEOUT:    cfg_tmo   = value;
			CFG_MISMATCH_WAIT:    cfg_mis   = value;
			CFG_ATTEMPT_LIMIT:    cfg_limit = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] pre, logic [7:0] idle, logic [15:0] tmo,
			logic [15:0] mis, logic [3:0] lim);
		write_reg(CFG_PRE_SEND_WAIT, pre);
		write_reg(CFG_IDLE_BEFORE_SEND, {8'd0, idle});
		write_reg(CFG_REPLY_TIMEOUT, tmo);
		write_reg(CFG_MISMATCH_WAIT, mis);
		write_reg(CFG_ATTEMPT_LIMIT, {12'd0, lim});
	endtask

	// Run random reads until n items have done something; ignored items are free
	task automatic run_reads(int n);
		srr_in_t it;
		bit      counts;
		int      done;
		done = 0;
		while (done < n) begin
			it = pick_item();
			counts = it.command == CMD_START
				|| (it.command == CMD_TICK && rq_phase != PH_IDLE)
				|| (it.command == CMD_RX && (rq_phase == PH_DRAIN || rq_phase == PH_COLLECT));
			send_item(it);
			if (counts)
				done++;
		end
	endtask

	// ---------------------------------------------------------------- receiver

	// Accept results with random stalls; on request hold off for a long stretch so
	// the output job fills and the block must stall its input.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
			end
			out_ready <= no_gaps || ($urandom_range(99) >= 6);
		end
	end

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= SHOW_MAX)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		srr_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("%0t: result with nothing owed, expected none, got %h",
						$time, out_item);
			end else begin
				want = owed_q.pop_front();
				check_field("kind", 32'(want.kind), 32'(out_item.kind));
				check_field("tx_byte", 32'(want.tx_byte), 32'(out_item.tx_byte));
				check_field("status", 32'(want.status), 32'(out_item.status));
				check_field("read_value", want.read_value, out_item.read_value);
				check_field("last", 32'(want.last), 32'(out_item.last));
			end
		end
	end

	// Give up when no item moves on either side for too long
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("sensor_param_read_requester_core_tb: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		srr_in_t it;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		no_gaps   = 1'b0;
		hold_req  = 1'b0;
		errors    = 0;
		owe_muted = 1'b0;
		stall_reply = 1'b0;
		drain_noise = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers first
		run_reads(60);

		// Directed table. All waits zero, so each read runs in a handful of items.
		script.push_back(row_reg(CFG_PRE_SEND_WAIT, 16'd0));
		script.push_back(row_reg(CFG_IDLE_BEFORE_SEND, 16'd0));
		script.push_back(row_reg(CFG_REPLY_TIMEOUT, 16'd0));
		script.push_back(row_reg(CFG_MISMATCH_WAIT, 16'd0));
		script.push_back(row_reg(CFG_ATTEMPT_LIMIT, 16'd0));
		// zero attempts: completion at once with the device-fail code
		script.push_back(row_done(CMD_START, 8'hFF, 8'h00, 8'h00, ST_DEVFAIL, 32'h0));
		// idle requester ignores ticks, bytes and the spare command
		script.push_back(row_item(CMD_TICK, 8'hFF, 8'hFF, 8'hFF));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'hFF));
		script.push_back(row_item(CMD_NONE, 8'hFF, 8'hFF, 8'h00));
		script.push_back(row_reg(CFG_ATTEMPT_LIMIT, 16'd1));
		// byte during the silence count, then a start that abandons the first read
		script.push_back(row_item(CMD_START, 8'hA5, 8'h3C, 8'h00));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'h5A));
		script.push_back(row_item(CMD_START, 8'h00, 8'hFF, 8'hFF));
		script.push_back(row_item(CMD_TICK, 8'h00, 8'h00, 8'h00));
		// zero timeout: first tick after the frame gives up
		script.push_back(row_done(CMD_TICK, 8'h00, 8'h00, 8'h00, ST_TIMEOUT, 32'h0));
		// clean read with extreme value bytes
		script.push_back(row_item(CMD_START, 8'hA5, 8'h3C, 8'h00));
		script.push_back(row_item(CMD_TICK, 8'h00, 8'h00, 8'h00));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'hA5));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'hD2));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'h00));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'hFF));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'h80));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'h7F));
		script.push_back(row_item(CMD_RX, 8'h00, 8'h00, 8'h3C));
		script.push_back(row_done(CMD_RX, 8'h00, 8'h00, 8'hB1, ST_OK, 32'h7F80FF00));

		foreach (script[n]) begin
			if (script[n].reg_row)
				write_reg(script[n].reg_idx, script[n].reg_val);
			else
				send_item(script[n].item, script[n].typed, script[n].want);
		end

		// Most attempts allowed, no mismatch wait, and a long run with no idling
		set_regs(16'd0, 8'd1, 16'd20, 16'd0, 4'd15);
		no_gaps = 1'b1;
		run_reads(80);
		no_gaps = 1'b0;

		// Short random settings, zero attempts among them now and then
		repeat (3) begin
			set_regs(16'($urandom_range(4)), 8'($urandom_range(4)), 16'($urandom_range(12)),
				16'($urandom_range(4)), 4'($urandom_range(4)));
			run_reads(50);
		end

		// Frames back to back while the receiver holds off: input must stall
		set_regs(16'd0, 8'd0, 16'd2, 16'd0, 4'd2);
		hold_req = 1'b1;
		run_reads(80);

		// Largest silence, timeout, mismatch-wait and attempt settings: a long silence requirement
		// that a stray byte restarts, then a start that abandons the read before the count completes
		set_regs(16'd1, 8'd255, WAIT_MAX, WAIT_MAX, 4'd15);
		send_item(rand_item(CMD_START));
		repeat (40) send_item(rand_item(CMD_TICK));
		it = rand_item(CMD_RX);
		send_item(it);
		repeat (40) send_item(rand_item(CMD_TICK));
		send_item(rand_item(CMD_START));
		repeat (20) send_item(rand_item(CMD_TICK));

		settle();
		if (errors == 0)
			$display("sensor_param_read_requester_core_tb: done, clean");
		else
			$display("sensor_param_read_requester_core_tb: done, errors");
		$finish;
	end

endmodule
